// ===== sv/dh_forward_kinematics_chain_assert.svh =====
// assertion helpers used by the checker file
`ifndef DH_FORWARD_KINEMATICS_CHAIN_ASSERT_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_ASSERT_SVH

// condition must hold at every sampled edge out of reset
`define DHFK_AST_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DHFK_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dhfk_pkg.sv =====
// ----------------------------------------------------------------------------
// dhfk_pkg
// Types, constants and helpers of the modified-DH forward kinematics chain.
// ----------------------------------------------------------------------------
package dhfk_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_MAX       = 30;
    localparam int CIW              = 5;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd326016437;
    localparam logic signed [30:0] ONE_Q29     = 31'sd536870912;

    // operand a select
    localparam logic [3:0] A_ROT0 = 4'd0;
    localparam logic [3:0] A_CA   = 4'd9;
    localparam logic [3:0] A_SA   = 4'd10;
    localparam logic [3:0] A_ST   = 4'd11;
    localparam logic [3:0] A_CT   = 4'd12;

    // operand b select
    localparam logic [3:0] B_LR0 = 4'd0;
    localparam logic [3:0] B_LT0 = 4'd9;
    localparam logic [3:0] B_D   = 4'd12;
    localparam logic [3:0] B_CA  = 4'd13;
    localparam logic [3:0] B_SA  = 4'd14;

    // accumulate destinations
    localparam logic [4:0] D_LR3 = 5'd0;
    localparam logic [4:0] D_LR4 = 5'd1;
    localparam logic [4:0] D_LR6 = 5'd2;
    localparam logic [4:0] D_LR7 = 5'd3;
    localparam logic [4:0] D_LT1 = 5'd4;
    localparam logic [4:0] D_LT2 = 5'd5;
    localparam logic [4:0] D_TR0 = 5'd6;
    localparam logic [4:0] D_NR0 = 5'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_FLIP,
        ST_LINK,
        ST_TRANS,
        ST_ROT,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic           load;
        logic           cordic_step;
        logic [CIW-1:0] cordic_iter;
        logic           cordic_flip;
        logic           mac_valid;
        logic [3:0]     a_sel;
        logic [3:0]     b_sel;
        logic           neg;
        logic           first;
        logic           last;
        logic [4:0]     dst;
        logic           commit;
    } t_cmd;

    typedef struct packed {
        logic commit_ok;
    } t_stat;

    function automatic logic signed [31:0] atan_of(input logic [CIW-1:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10680862;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            5'd24:   v = 32'sd41;
            5'd25:   v = 32'sd20;
            5'd26:   v = 32'sd10;
            5'd27:   v = 32'sd5;
            5'd28:   v = 32'sd3;
            5'd29:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [30:0] sat31(input logic signed [39:0] v);
        logic signed [30:0] r;
        if (v > 40'sd1073741823) begin
            r = 31'sh3fffffff;
        end else if (v < -40'sd1073741824) begin
            r = 31'sh40000000;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/dhfk_if.sv =====
// ----------------------------------------------------------------------------
// dhfk_link_if / dhfk_pose_if
// Valid/ready channels for link items and pose items.
// ----------------------------------------------------------------------------
interface dhfk_link_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] link_twist;
    logic signed [31:0] link_length;
    logic signed [31:0] link_offset;
    logic signed [15:0] theta_offset;
    logic signed [15:0] joint_angle;
    logic               last_link;

    modport source (output valid, link_twist, link_length, link_offset, theta_offset,
                    joint_angle, last_link, input ready);
    modport sink   (input valid, link_twist, link_length, link_offset, theta_offset,
                    joint_angle, last_link, output ready);
endinterface

interface dhfk_pose_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] px, py, pz;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    px, py, pz, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    px, py, pz, output ready);
endinterface

// ===== sv/dhfk_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhfk_ctrl
// Sequencer: CORDIC iterations, then the multiply-accumulate schedule, commit.
// ----------------------------------------------------------------------------
module dhfk_ctrl #(
    parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dhfk_pkg::t_stat i_stat,
    output dhfk_pkg::t_cmd  o_cmd
);
    import dhfk_pkg::*;

    t_state         r_state, n_state;
    logic [CIW-1:0] r_cnt, n_cnt;
    logic [1:0]     r_i, n_i, r_j, n_j, r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.cordic_iter = r_cnt;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (r_cnt == CIW'(CORDIC_STEPS - 1)) begin
                    n_state = ST_FLIP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FLIP: begin
                o_cmd.cordic_flip = 1'b1;
                n_cnt   = '0;
                n_state = ST_LINK;
            end
            ST_LINK: begin
                // single-product terms of the link transform
                o_cmd.mac_valid = 1'b1;
                o_cmd.first     = 1'b1;
                o_cmd.last      = 1'b1;
                case (r_cnt)
                    5'd0: begin
                        o_cmd.a_sel = A_ST; o_cmd.b_sel = B_CA; o_cmd.dst = D_LR3;
                    end
                    5'd1: begin
                        o_cmd.a_sel = A_CT; o_cmd.b_sel = B_CA; o_cmd.dst = D_LR4;
                    end
                    5'd2: begin
                        o_cmd.a_sel = A_ST; o_cmd.b_sel = B_SA; o_cmd.dst = D_LR6;
                    end
                    5'd3: begin
                        o_cmd.a_sel = A_CT; o_cmd.b_sel = B_SA; o_cmd.dst = D_LR7;
                    end
                    5'd4: begin
                        o_cmd.a_sel = A_SA; o_cmd.b_sel = B_D; o_cmd.dst = D_LT1;
                        o_cmd.neg   = 1'b1;
                    end
                    default: begin
                        o_cmd.a_sel = A_CA; o_cmd.b_sel = B_D; o_cmd.dst = D_LT2;
                    end
                endcase
                if (r_cnt == 5'd5) begin
                    n_i     = '0;
                    n_k     = '0;
                    n_state = ST_TRANS;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_TRANS: begin
                o_cmd.mac_valid = 1'b1;
                o_cmd.a_sel = A_ROT0 + {2'b00, r_i} * 4'd3 + {2'b00, r_k};
                o_cmd.b_sel = B_LT0 + {2'b00, r_k};
                o_cmd.first = (r_k == 2'd0);
                o_cmd.last  = (r_k == 2'd2);
                o_cmd.dst   = D_TR0 + {3'b000, r_i};
                if (r_k == 2'd2) begin
                    n_k = '0;
                    if (r_i == 2'd2) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = ST_ROT;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_ROT: begin
                o_cmd.mac_valid = 1'b1;
                o_cmd.a_sel = A_ROT0 + {2'b00, r_i} * 4'd3 + {2'b00, r_k};
                o_cmd.b_sel = B_LR0 + {2'b00, r_k} * 4'd3 + {2'b00, r_j};
                o_cmd.first = (r_k == 2'd0);
                o_cmd.last  = (r_k == 2'd2);
                o_cmd.dst   = D_NR0 + {3'b000, r_i} * 5'd3 + {3'b000, r_j};
                if (r_k == 2'd2) begin
                    n_k = '0;
                    if (r_j == 2'd2) begin
                        n_j = '0;
                        if (r_i == 2'd2) begin
                            n_i     = '0;
                            n_state = ST_DRAIN;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_DRAIN: begin
                // last accumulate lands this cycle
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_stat.commit_ok) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/dhfk_datapath.sv =====
// ----------------------------------------------------------------------------
// dhfk_datapath
// Two CORDIC units, one multiplier with accumulator, pose and output registers.
// ----------------------------------------------------------------------------
module dhfk_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dhfk_pkg::t_cmd     i_cmd,
    output dhfk_pkg::t_stat    o_stat,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic signed [15:0] i_link_twist,
    input  logic signed [31:0] i_link_length,
    input  logic signed [31:0] i_link_offset,
    input  logic signed [15:0] i_theta_offset,
    input  logic signed [15:0] i_joint_angle,
    input  logic               i_last_link,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [30:0] o_rot [9],
    output logic signed [31:0] o_pos [3]
);
    import dhfk_pkg::*;

    logic               r_emit;
    logic signed [31:0] r_len, r_off;
    logic               r_last;

    // cordic unit 0 works on the twist, unit 1 on theta
    logic signed [31:0] r_x [2];
    logic signed [31:0] r_y [2];
    logic signed [33:0] r_z [2];
    logic               r_flip [2];

    logic signed [31:0] r_lr [4];
    logic signed [31:0] r_lt1, r_lt2;
    logic signed [30:0] r_rot [9];
    logic signed [30:0] r_nr [9];
    logic signed [31:0] r_trans [3];

    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;
    logic               r_m_valid, r_m_neg, r_m_first, r_m_last;
    logic [4:0]         r_m_dst;

    logic               r_ovalid;
    logic signed [30:0] r_out_rot [9];
    logic signed [31:0] r_out_pos [3];

    logic [15:0]        w_theta;
    logic signed [33:0] w_z0 [2];
    logic               w_f0 [2];
    logic signed [31:0] w_lr [9];
    logic signed [31:0] w_lt [3];
    logic signed [31:0] w_opa, w_opb;
    logic signed [65:0] w_sum, w_rs;
    logic signed [39:0] w_rnd;
    logic               w_emit;

    assign w_theta = i_theta_offset + i_joint_angle;

    // fold angles beyond a quarter turn by half a turn
    always_comb begin
        logic signed [33:0] z;
        for (int u = 0; u < 2; u++) begin
            z = (u == 0) ? {{2{i_link_twist[15]}}, i_link_twist, 16'h0000}
                         : {{2{w_theta[15]}}, w_theta, 16'h0000};
            if (z > 34'sd1073741824) begin
                w_z0[u] = z - 34'sd2147483648;
                w_f0[u] = 1'b1;
            end else if (z < -34'sd1073741824) begin
                w_z0[u] = z + 34'sd2147483648;
                w_f0[u] = 1'b1;
            end else begin
                w_z0[u] = z;
                w_f0[u] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len  <= i_link_length;
            r_off  <= i_link_offset;
            r_last <= i_last_link;
            for (int u = 0; u < 2; u++) begin
                r_x[u]    <= CORDIC_GAIN;
                r_y[u]    <= '0;
                r_z[u]    <= w_z0[u];
                r_flip[u] <= w_f0[u];
            end
        end else if (i_cmd.cordic_step) begin
            for (int u = 0; u < 2; u++) begin
                if (!r_z[u][33]) begin
                    r_x[u] <= r_x[u] - (r_y[u] >>> i_cmd.cordic_iter);
                    r_y[u] <= r_y[u] + (r_x[u] >>> i_cmd.cordic_iter);
                    r_z[u] <= r_z[u] - 34'(atan_of(i_cmd.cordic_iter));
                end else begin
                    r_x[u] <= r_x[u] + (r_y[u] >>> i_cmd.cordic_iter);
                    r_y[u] <= r_y[u] - (r_x[u] >>> i_cmd.cordic_iter);
                    r_z[u] <= r_z[u] + 34'(atan_of(i_cmd.cordic_iter));
                end
            end
        end else if (i_cmd.cordic_flip) begin
            for (int u = 0; u < 2; u++) begin
                if (r_flip[u]) begin
                    r_x[u] <= -r_x[u];
                    r_y[u] <= -r_y[u];
                end
            end
        end
    end

    // link rotation and translation as operand vectors
    always_comb begin
        w_lr[0] = r_x[1];
        w_lr[1] = -r_y[1];
        w_lr[2] = '0;
        w_lr[3] = r_lr[0];
        w_lr[4] = r_lr[1];
        w_lr[5] = -r_y[0];
        w_lr[6] = r_lr[2];
        w_lr[7] = r_lr[3];
        w_lr[8] = r_x[0];
        w_lt[0] = r_len;
        w_lt[1] = r_lt1;
        w_lt[2] = r_lt2;
    end

    always_comb begin
        case (i_cmd.a_sel)
            A_CA:    w_opa = r_x[0];
            A_SA:    w_opa = r_y[0];
            A_ST:    w_opa = r_y[1];
            A_CT:    w_opa = r_x[1];
            default: w_opa = (i_cmd.a_sel < 4'd9) ? 32'(r_rot[i_cmd.a_sel]) : '0;
        endcase
        case (i_cmd.b_sel)
            B_D:     w_opb = r_off;
            B_CA:    w_opb = r_x[0];
            B_SA:    w_opb = r_y[0];
            default: begin
                if (i_cmd.b_sel < B_LT0) begin
                    w_opb = w_lr[i_cmd.b_sel];
                end else if (i_cmd.b_sel < B_D) begin
                    w_opb = w_lt[2'(i_cmd.b_sel - B_LT0)];
                end else begin
                    w_opb = '0;
                end
            end
        endcase
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= i_cmd.mac_valid;
        end
        r_prod    <= w_opa * w_opb;
        r_m_neg   <= i_cmd.neg;
        r_m_first <= i_cmd.first;
        r_m_last  <= i_cmd.last;
        r_m_dst   <= i_cmd.dst;
    end

    // accumulate stage, round half up by 2^29
    assign w_sum = (r_m_first ? 66'sd0 : r_acc) + (r_m_neg ? -66'(r_prod) : 66'(r_prod));
    assign w_rs  = (w_sum + 66'sd268435456) >>> 29;
    assign w_rnd = w_rs[39:0];
    assign w_emit = r_emit || r_last;

    assign o_stat.commit_ok = !w_emit || !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (r_m_valid) begin
            r_acc <= w_sum;
            if (r_m_last) begin
                case (r_m_dst)
                    D_LR3:   r_lr[0] <= w_rnd[31:0];
                    D_LR4:   r_lr[1] <= w_rnd[31:0];
                    D_LR6:   r_lr[2] <= w_rnd[31:0];
                    D_LR7:   r_lr[3] <= w_rnd[31:0];
                    D_LT1:   r_lt1   <= sat32(w_rnd);
                    D_LT2:   r_lt2   <= sat32(w_rnd);
                    default: begin
                        if (r_m_dst >= D_NR0 && r_m_dst < 5'd18) begin
                            r_nr[4'(r_m_dst - D_NR0)] <= sat31(w_rnd);
                        end
                    end
                endcase
            end
        end
    end

    // pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < 9; e++) begin
                r_rot[e] <= (e % 4 == 0) ? ONE_Q29 : '0;
            end
            for (int e = 0; e < 3; e++) begin
                r_trans[e] <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int e = 0; e < 9; e++) begin
                if (r_last) begin
                    r_rot[e] <= (e % 4 == 0) ? ONE_Q29 : '0;
                end else begin
                    r_rot[e] <= r_nr[e];
                end
            end
            if (r_last) begin
                for (int e = 0; e < 3; e++) begin
                    r_trans[e] <= '0;
                end
            end
        end else if (r_m_valid && r_m_last && r_m_dst >= D_TR0 && r_m_dst < D_NR0) begin
            r_trans[2'(r_m_dst - D_TR0)] <=
                sat32(40'(r_trans[2'(r_m_dst - D_TR0)]) + w_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_emit <= i_cfg_wdata;
            end
            if (i_cmd.commit && w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (i_cmd.commit && w_emit) begin
            r_out_rot <= r_nr;
            r_out_pos <= r_trans;
        end
    end

    assign o_valid = r_ovalid;
    assign o_rot   = r_out_rot;
    assign o_pos   = r_out_pos;

endmodule

// ===== sv/dh_forward_kinematics_chain.sv =====
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain
// Modified-DH forward kinematics: accumulates link transforms into a pose.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_link    in   valid/ready     twist, length, offset, theta offset, joint, last
//  o_pose    out  valid/ready     r00..r22 (Q2.29), px/py/pz (Q20)
//  i_cfg     in   write enable    emit_every_frame
//
//  one link item runs the CORDIC iterations, then 42 products through the
//  single multiplier and accumulator
//  a link is taken only when the sequencer is idle
//  a pending pose item stalls a commit that emits a pose until the sink takes the older one
//  synchronous active-low reset gives identity pose and emit_every_frame = 0
module dh_forward_kinematics_chain #(
    parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dhfk_link_if.sink    i_link,
    dhfk_pose_if.source  o_pose,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata
);
    import dhfk_pkg::*;

    t_cmd               w_cmd;
    t_stat              w_stat;
    logic               w_in_ready;
    logic signed [30:0] w_rot [9];
    logic signed [31:0] w_pos [3];

    dhfk_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_link.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    dhfk_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_link_twist   (i_link.link_twist),
        .i_link_length  (i_link.link_length),
        .i_link_offset  (i_link.link_offset),
        .i_theta_offset (i_link.theta_offset),
        .i_joint_angle  (i_link.joint_angle),
        .i_last_link    (i_link.last_link),
        .o_valid        (o_pose.valid),
        .i_ready        (o_pose.ready),
        .o_rot          (w_rot),
        .o_pos          (w_pos)
    );

    assign i_link.ready = w_in_ready;
    assign o_pose.r00 = w_rot[0];
    assign o_pose.r01 = w_rot[1];
    assign o_pose.r02 = w_rot[2];
    assign o_pose.r10 = w_rot[3];
    assign o_pose.r11 = w_rot[4];
    assign o_pose.r12 = w_rot[5];
    assign o_pose.r20 = w_rot[6];
    assign o_pose.r21 = w_rot[7];
    assign o_pose.r22 = w_rot[8];
    assign o_pose.px  = w_pos[0];
    assign o_pose.py  = w_pos[1];
    assign o_pose.pz  = w_pos[2];

endmodule

// ===== sv/dhfk_checker.sv =====
// ----------------------------------------------------------------------------
// dhfk_checker
// Port-level checks of the forward kinematics chain, bound to the top level.
// ----------------------------------------------------------------------------
`include "dh_forward_kinematics_chain_assert.svh"

module dhfk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_out_px
);

    // a stalled pose item stays offered
    `DHFK_AST_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "pose item dropped")

    // and keeps its payload (px is checked)
    `DHFK_AST_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_px), "pose changed")

    // one link at a time: the sequencer is busy right after an accept
    `DHFK_AST_NEXT(a_one_link, i_in_valid && i_in_ready, !i_in_ready, "second link taken")

    // a pose needs the whole link computation, never the cycle after an accept
    `DHFK_AST_ALWAYS(a_no_early, !($rose(i_out_valid) && $past(i_in_valid && i_in_ready)), "early pose")

endmodule

bind dh_forward_kinematics_chain dhfk_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_link.valid),
    .i_in_ready  (i_link.ready),
    .i_out_valid (o_pose.valid),
    .i_out_ready (o_pose.ready),
    .i_out_px    (o_pose.px)
);
